/* hw/rtl/dvrt_pkg.sv */
package dvrt_pkg;

    localparam int NEIGHBOURS_DEF    = 8;
    localparam int ROUTES_DEF        = 16;
    localparam int COST_INFINITY_DEF = 16;

    localparam logic [2:0] KIND_HELLO  = 3'd0;
    localparam logic [2:0] KIND_UPDATE = 3'd1;
    localparam logic [2:0] KIND_TICK   = 3'd2;
    localparam logic [2:0] KIND_LOOKUP = 3'd3;
    localparam logic [2:0] KIND_EXPORT = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NB_FULL  = 2'd1;
    localparam logic [1:0] ST_RT_FULL  = 2'd2;
    localparam logic [1:0] ST_MISSING  = 2'd3;

    localparam logic [1:0] NB_INIT         = 2'd0;
    localparam logic [1:0] NB_CONNECTED    = 2'd1;
    localparam logic [1:0] NB_DISCONNECTED = 2'd2;

    localparam logic REG_DISCONNECT = 1'b0;
    localparam logic REG_REFRESH    = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NB_SCAN,
        S_RT_SCAN,
        S_RT_WAIT,
        S_TICK_NB,
        S_TICK_RT,
        S_DONE
    } t_state;

endpackage

/* hw/rtl/dvrt_ram.sv */
module dvrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* hw/rtl/distance_vector_route_table.sv */
// Distance-vector route table with split horizon and route poisoning.
// Input channel: i_valid/o_stall with fields i_kind, i_peer_address,
// i_dst_address, i_cost_in, i_ttl_in, i_route_index. Output channel:
// o_valid/i_stall with one result word per input word.
// A word is taken only while the block is idle (o_stall low). The sequencer
// then walks the neighbour table one entry a cycle, except that a tick holds
// the walk at each stale neighbour while it poisons that neighbour's routes;
// the route table, a memory with a registered read, is walked with a read
// state and a compare state per entry. An export only waits for its read;
// update and lookup scan the route table, and hello scans the neighbour
// table, then the route table for a neighbour that was disconnected. The
// next word can be taken in the cycle after the result has been handed over;
// while the receiver stalls, the result holds and the input stays stalled.
// Reset clears the counts, the change flag and the quiet counter, and sets
// the registers to 3 and 2. Table entries need no clearing: only entries
// below the counts are read. Configuration is written via i_cfg_we,
// i_cfg_index and i_cfg_data.
module distance_vector_route_table #(
    parameter int NEIGHBOURS    = dvrt_pkg::NEIGHBOURS_DEF,
    parameter int ROUTES        = dvrt_pkg::ROUTES_DEF,
    parameter int COST_INFINITY = dvrt_pkg::COST_INFINITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [2:0] i_kind,
    input  logic [7:0] i_peer_address,
    input  logic [7:0] i_dst_address,
    input  logic [4:0] i_cost_in,
    input  logic [3:0] i_ttl_in,
    input  logic [3:0] i_route_index,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_status,
    output logic       o_send_hello,
    output logic       o_send_update,
    output logic       o_found,
    output logic [7:0] o_gateway,
    output logic [3:0] o_ttl_out,
    output logic [7:0] o_route_dst,
    output logic [4:0] o_route_cost,
    output logic       o_export_keep
);

    localparam int NBW = (NEIGHBOURS > 1) ? $clog2(NEIGHBOURS) : 1;
    localparam int RTW = (ROUTES > 1) ? $clog2(ROUTES) : 1;
    localparam int NCW = $clog2(NEIGHBOURS + 1);
    localparam int RCW = $clog2(ROUTES + 1);
    localparam int RW  = 8 + 8 + 5;
    localparam logic [4:0] CINF = 5'(COST_INFINITY);

    dvrt_pkg::t_state r_state, n_state;

    logic [7:0] r_disc, r_refresh;
    logic [7:0] r_nb_addr [NEIGHBOURS];
    logic [1:0] r_nb_stat [NEIGHBOURS];
    logic [7:0] r_nb_age  [NEIGHBOURS];
    logic [NCW-1:0] r_nb_count;
    logic [RCW-1:0] r_rt_count;
    logic r_change;
    logic [7:0] r_quiet;

    // Latched item and scan state.
    logic [2:0] r_kind;
    logic [7:0] r_peer, r_dst;
    logic [4:0] r_cost;
    logic [3:0] r_ttl, r_idx;
    logic [NCW-1:0] r_ni;
    logic [RCW-1:0] r_ri;

    // Result word.
    logic [1:0] r_status;
    logic r_hello, r_update, r_found, r_keep;
    logic [7:0] r_hop, r_rdst;
    logic [3:0] r_ttlo;
    logic [4:0] r_rcost;

    // Route memory.
    logic          ram_we;
    logic [RTW-1:0] ram_waddr, ram_raddr;
    logic [RW-1:0] ram_wdata, ram_rdata;
    logic [7:0] rd_dst, rd_hop;
    logic [4:0] rd_cost;

    dvrt_ram #(.WIDTH(RW), .DEPTH(ROUTES)) u_rt (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );
    assign rd_dst  = ram_rdata[20:13];
    assign rd_hop  = ram_rdata[12:5];
    assign rd_cost = ram_rdata[4:0];

    logic in_acc;
    assign in_acc  = i_valid && !o_stall;
    assign o_stall = (r_state != dvrt_pkg::S_IDLE);
    assign o_valid = (r_state == dvrt_pkg::S_DONE);

    // Saturated advertised cost plus one.
    logic [4:0] upd_cost;
    assign upd_cost = (r_cost >= CINF) ? CINF : r_cost + 5'd1;

    // Current neighbour index and the route-scan shared compare.
    logic [NBW-1:0] nix;
    logic [RTW-1:0] rix;
    logic rt_end, nb_end;
    assign nix    = r_ni[NBW-1:0];
    assign rix    = r_ri[RTW-1:0];
    assign rt_end = (r_ri >= r_rt_count);
    assign nb_end = (r_ni >= r_nb_count);
    logic [7:0] key;
    logic key_hit;
    assign key     = (r_kind == dvrt_pkg::KIND_TICK) ? r_nb_addr[nix] : r_dst;
    assign key_hit = (r_kind == dvrt_pkg::KIND_TICK) ? (rd_hop == key) : (rd_dst == key);
    logic [7:0] tick_age;
    assign tick_age = (r_nb_age[nix] == 8'hff) ? 8'hff : r_nb_age[nix] + 8'd1;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            dvrt_pkg::S_IDLE: begin
                if (in_acc) begin
                    case (i_kind)
                        dvrt_pkg::KIND_HELLO:  n_state = dvrt_pkg::S_NB_SCAN;
                        dvrt_pkg::KIND_UPDATE,
                        dvrt_pkg::KIND_LOOKUP: n_state = dvrt_pkg::S_RT_SCAN;
                        dvrt_pkg::KIND_TICK:   n_state = dvrt_pkg::S_TICK_NB;
                        dvrt_pkg::KIND_EXPORT: n_state = dvrt_pkg::S_RT_WAIT;
                        default:               n_state = dvrt_pkg::S_DONE;
                    endcase
                end
            end
            dvrt_pkg::S_NB_SCAN: begin
                if (nb_end || r_nb_addr[nix] == r_peer) begin
                    n_state = dvrt_pkg::S_DONE;
                    if (nb_end && r_nb_count < NCW'(NEIGHBOURS)) begin
                        n_state = dvrt_pkg::S_DONE;
                    end else if (!nb_end && r_nb_stat[nix] == dvrt_pkg::NB_DISCONNECTED) begin
                        n_state = dvrt_pkg::S_RT_SCAN;
                    end
                end
            end
            dvrt_pkg::S_RT_SCAN: begin
                n_state = rt_end ? dvrt_pkg::S_DONE : dvrt_pkg::S_RT_WAIT;
            end
            dvrt_pkg::S_RT_WAIT: begin
                if (r_kind == dvrt_pkg::KIND_EXPORT) begin
                    n_state = dvrt_pkg::S_DONE;
                end else if (key_hit) begin
                    n_state = dvrt_pkg::S_DONE;
                end else begin
                    n_state = dvrt_pkg::S_RT_SCAN;
                end
            end
            dvrt_pkg::S_TICK_NB: begin
                if (nb_end) begin
                    n_state = dvrt_pkg::S_DONE;
                end else if (r_nb_stat[nix] != dvrt_pkg::NB_DISCONNECTED
                             && tick_age > r_disc) begin
                    n_state = dvrt_pkg::S_TICK_RT;
                end
            end
            dvrt_pkg::S_TICK_RT: begin
                // Reads alternate with compares in the wait state of a tick.
                n_state = rt_end ? dvrt_pkg::S_TICK_NB : dvrt_pkg::S_RT_WAIT;
            end
            dvrt_pkg::S_DONE: begin
                if (!i_stall) begin
                    n_state = dvrt_pkg::S_IDLE;
                end
            end
            default: n_state = dvrt_pkg::S_IDLE;
        endcase
        // A tick's route pass returns to the poison scan, never ends the item.
        if (r_state == dvrt_pkg::S_RT_WAIT && r_kind == dvrt_pkg::KIND_TICK) begin
            n_state = dvrt_pkg::S_TICK_RT;
        end
    end

    // Memory port control.
    always_comb begin
        ram_raddr = rix;
        ram_we    = 1'b0;
        ram_waddr = rix;
        ram_wdata = {r_dst, r_peer, upd_cost};
        if (r_state == dvrt_pkg::S_IDLE) begin
            ram_raddr = i_route_index[RTW-1:0];
        end
        case (r_state)
            dvrt_pkg::S_NB_SCAN: begin
                // Cost-1 route of a new neighbour.
                ram_waddr = r_rt_count[RTW-1:0];
                ram_wdata = {r_peer, r_peer, 5'd1};
                ram_we    = nb_end && r_nb_count < NCW'(NEIGHBOURS)
                            && r_rt_count < RCW'(ROUTES);
            end
            dvrt_pkg::S_RT_SCAN: begin
                if (rt_end && r_kind == dvrt_pkg::KIND_UPDATE) begin
                    ram_waddr = r_rt_count[RTW-1:0];
                    ram_we    = r_rt_count < RCW'(ROUTES);
                end
            end
            dvrt_pkg::S_RT_WAIT: begin
                if (r_kind == dvrt_pkg::KIND_TICK) begin
                    ram_wdata = {rd_dst, rd_hop, CINF};
                    ram_we    = key_hit;
                end else if (r_kind == dvrt_pkg::KIND_HELLO) begin
                    ram_wdata = {rd_dst, r_peer, 5'd1};
                    ram_we    = key_hit;
                end else if (r_kind == dvrt_pkg::KIND_UPDATE) begin
                    ram_wdata = {rd_dst, r_peer, upd_cost};
                    ram_we    = key_hit && (rd_hop == r_peer || upd_cost < rd_cost);
                end
            end
            default: ;
        endcase
    end

    // Registers and results.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= dvrt_pkg::S_IDLE;
            r_disc     <= 8'd3;
            r_refresh  <= 8'd2;
            r_nb_count <= '0;
            r_rt_count <= '0;
            r_change   <= 1'b0;
            r_quiet    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    dvrt_pkg::REG_DISCONNECT: r_disc    <= i_cfg_data;
                    dvrt_pkg::REG_REFRESH:    r_refresh <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                dvrt_pkg::S_IDLE: begin
                    if (in_acc) begin
                        r_kind <= i_kind;
                        r_peer <= i_peer_address;
                        r_dst  <= (i_kind == dvrt_pkg::KIND_HELLO) ? i_peer_address
                                                                    : i_dst_address;
                        r_cost <= i_cost_in;
                        r_ttl  <= i_ttl_in;
                        r_idx  <= i_route_index;
                        r_ni   <= '0;
                        r_ri   <= '0;
                        r_status <= dvrt_pkg::ST_OK;
                        r_hello  <= 1'b0;
                        r_update <= 1'b0;
                        r_found  <= 1'b0;
                        r_keep   <= 1'b0;
                        r_hop    <= '0;
                        r_rdst   <= '0;
                        r_rcost  <= '0;
                        r_ttlo   <= (i_kind == dvrt_pkg::KIND_LOOKUP) ? i_ttl_in : 4'd0;
                    end
                end
                dvrt_pkg::S_NB_SCAN: begin
                    if (nb_end) begin
                        if (r_nb_count < NCW'(NEIGHBOURS)) begin
                            r_nb_addr[r_nb_count[NBW-1:0]] <= r_peer;
                            r_nb_stat[r_nb_count[NBW-1:0]] <= dvrt_pkg::NB_INIT;
                            r_nb_age[r_nb_count[NBW-1:0]]  <= '0;
                            r_nb_count <= r_nb_count + 1'b1;
                            r_change   <= 1'b1;
                            if (r_rt_count < RCW'(ROUTES)) begin
                                r_rt_count <= r_rt_count + 1'b1;
                            end else begin
                                r_status <= dvrt_pkg::ST_RT_FULL;
                            end
                        end else begin
                            r_status <= dvrt_pkg::ST_NB_FULL;
                        end
                    end else if (r_nb_addr[nix] == r_peer) begin
                        // A known neighbour is connected from now on, whatever it was.
                        r_nb_age[nix]  <= '0;
                        r_nb_stat[nix] <= dvrt_pkg::NB_CONNECTED;
                    end else begin
                        r_ni <= r_ni + 1'b1;
                    end
                end
                dvrt_pkg::S_RT_SCAN: begin
                    if (rt_end) begin
                        if (r_kind == dvrt_pkg::KIND_UPDATE) begin
                            if (r_rt_count < RCW'(ROUTES)) begin
                                r_rt_count <= r_rt_count + 1'b1;
                            end else begin
                                r_status <= dvrt_pkg::ST_RT_FULL;
                            end
                        end else begin
                            r_status <= dvrt_pkg::ST_MISSING;
                        end
                    end
                end
                dvrt_pkg::S_RT_WAIT: begin
                    if (r_kind == dvrt_pkg::KIND_EXPORT) begin
                        if (RCW'(r_idx) < r_rt_count && 32'(r_idx) < ROUTES) begin
                            r_found <= 1'b1;
                            r_hop   <= rd_hop;
                            r_rdst  <= rd_dst;
                            r_rcost <= rd_cost;
                            r_keep  <= (rd_hop != r_peer) && (rd_dst != r_peer);
                        end else begin
                            r_status <= dvrt_pkg::ST_MISSING;
                        end
                    end else if (r_kind == dvrt_pkg::KIND_LOOKUP && key_hit) begin
                        r_found <= 1'b1;
                        r_hop   <= rd_hop;
                        r_ttlo  <= (r_ttl != 4'd0) ? r_ttl - 4'd1 : 4'd0;
                    end
                    r_ri <= r_ri + 1'b1;
                end
                dvrt_pkg::S_TICK_NB: begin
                    if (nb_end) begin
                        r_hello <= 1'b1;
                        if (r_change || r_quiet >= r_refresh) begin
                            r_update <= 1'b1;
                            r_change <= 1'b0;
                            r_quiet  <= '0;
                        end else if (r_quiet != 8'hff) begin
                            r_quiet <= r_quiet + 8'd1;
                        end
                    end else begin
                        r_ri <= '0;
                        if (r_nb_stat[nix] != dvrt_pkg::NB_DISCONNECTED) begin
                            r_nb_age[nix] <= tick_age;
                            if (tick_age > r_disc) begin
                                r_nb_stat[nix] <= dvrt_pkg::NB_DISCONNECTED;
                                r_change <= 1'b1;
                            end else begin
                                r_ni <= r_ni + 1'b1;
                            end
                        end else begin
                            r_ni <= r_ni + 1'b1;
                        end
                    end
                end
                dvrt_pkg::S_TICK_RT: begin
                    if (rt_end) begin
                        r_ni <= r_ni + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_status      = r_status;
    assign o_send_hello  = r_hello;
    assign o_send_update = r_update;
    assign o_found       = r_found;
    assign o_gateway     = r_hop;
    assign o_ttl_out     = r_ttlo;
    assign o_route_dst   = r_rdst;
    assign o_route_cost  = r_rcost;
    assign o_export_keep = r_keep;

    // The block takes no word while a result is held.
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("input taken while result held");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid) else $error("result dropped under stall");
    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nb_count <= NCW'(NEIGHBOURS) && r_rt_count <= RCW'(ROUTES))
        else $error("table count overflow");

endmodule
